### hw/rtl/ffba_pkg.sv
// Package: types, constants and codes shared by the first-fit allocator files.
`default_nettype none
package ffba_pkg;

   localparam int OFFSET_W = 20;
   localparam int SIZE_W   = 21;
   localparam int STATUS_W = 2;

   localparam int DEF_HEAP_BYTES   = 1048576;
   localparam int DEF_HEADER_BYTES = 32;
   localparam int DEF_MAX_BLOCKS   = 64;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_NO_SPACE  = 2'd1,
      STS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TAKE,
      OP_SPLIT,
      OP_MERGE,
      OP_FREE
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIT1,
      ST_COAL,
      ST_FIT2,
      ST_FIND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                used;
      logic                free;
      logic [OFFSET_W-1:0] start;
      logic [OFFSET_W-1:0] len;
   } entry_type;

   typedef struct packed {
      cell_op_type         op;
      logic                restart;
      logic                advance;
      logic [SIZE_W-1:0]   size;
      logic [OFFSET_W-1:0] offset;
   } cell_ctl_type;

   typedef struct packed {
      logic                used;
      logic                fit;
      logic                match;
      logic                mergeable;
      logic                splitable;
      logic [OFFSET_W-1:0] start;
   } cell_stat_type;

endpackage
`default_nettype wire

### hw/rtl/ffba_req_if.sv
// Interface: request channel of the allocator.
`default_nettype none
interface ffba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [ffba_pkg::SIZE_W-1:0]   request_size;
   logic [ffba_pkg::OFFSET_W-1:0] release_offset;

   modport source (output valid, command, request_size, release_offset, input ready);
   modport sink   (input valid, command, request_size, release_offset, output ready);
endinterface
`default_nettype wire

### hw/rtl/ffba_rsp_if.sv
// Interface: response channel of the allocator.
`default_nettype none
interface ffba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffba_pkg::STATUS_W-1:0] status;
   logic [ffba_pkg::OFFSET_W-1:0] payload_offset;

   modport source (output valid, status, payload_offset, input ready);
   modport sink   (input valid, status, payload_offset, output ready);
endinterface
`default_nettype wire

### hw/rtl/first_fit_block_allocator_top.sv
// Top level: first-fit heap allocator built as a row of block-table cells.
// Sequence: an allocate runs the fit scan, then coalescing and a second scan
//   when the first scan finds no fit; a free runs the match scan, then coalescing
//   when the block is found; every item ends with a response.
// Items: one item at a time; the next item is taken in the idle cycle that
//   follows the accepted response.
// Reset (synchronous): the table holds one free block at the header offset.
`default_nettype none
module first_fit_block_allocator_top #(
   parameter int HEAP_BYTES   = ffba_pkg::DEF_HEAP_BYTES,
   parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
   parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS
) (
   input  wire         clock,
   input  wire         reset,
   ffba_req_if.sink    req_ch,
   ffba_rsp_if.source  rsp_ch
);
   import ffba_pkg::*;

   // Cell row: each cell holds one table entry plus one bit of the
   // thermometer-coded scan pointer. Entries shift toward higher cells on a
   // split and toward lower cells on a merge.
   entry_type     ent  [MAX_BLOCKS];
   logic          pos  [MAX_BLOCKS];
   cell_stat_type st   [MAX_BLOCKS];
   cell_stat_type stat;
   cell_ctl_type  ctl;

   genvar k;
   generate
      for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
         entry_type left_ent, right_ent;
         logic      pos_left, pos_right;

         if (k == 0) begin : g_lo
            assign left_ent = '0;
            assign pos_left = 1'b1;
         end else begin : g_lo
            assign left_ent = ent[k-1];
            assign pos_left = pos[k-1];
         end

         if (k == MAX_BLOCKS - 1) begin : g_hi
            assign right_ent = '0;
            assign pos_right = 1'b0;
         end else begin : g_hi
            assign right_ent = ent[k+1];
            assign pos_right = pos[k+1];
         end

         ffba_cell #(
            .FIRST        (k == 0),
            .HEAP_BYTES   (HEAP_BYTES),
            .HEADER_BYTES (HEADER_BYTES)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .left_ent  (left_ent),
            .right_ent (right_ent),
            .pos_left  (pos_left),
            .pos_right (pos_right),
            .ent_out   (ent[k]),
            .pos_out   (pos[k]),
            .stat_out  (st[k])
         );
      end
   endgenerate

   // Only the cell under the pointer drives a nonzero status; gather it.
   always_comb begin
      stat = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         stat = cell_stat_type'(stat | st[i]);
      end
   end

   ffba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .stat     (stat),
      .last_tok (pos[MAX_BLOCKS-1]),
      .full     (ent[MAX_BLOCKS-1].used),
      .ctl      (ctl)
   );

endmodule
`default_nettype wire

### hw/rtl/ffba_cell.sv
// Module: one table cell holding a block entry and its share of the scan pointer.
`default_nettype none
module ffba_cell #(
   parameter bit FIRST        = 1'b0,
   parameter int HEAP_BYTES   = ffba_pkg::DEF_HEAP_BYTES,
   parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
   input  wire                      clock,
   input  wire                      reset,
   input  ffba_pkg::cell_ctl_type   ctl,
   input  ffba_pkg::entry_type      left_ent,
   input  ffba_pkg::entry_type      right_ent,
   input  wire                      pos_left,
   input  wire                      pos_right,
   output ffba_pkg::entry_type      ent_out,
   output logic                     pos_out,
   output ffba_pkg::cell_stat_type  stat_out
);
   import ffba_pkg::*;

   entry_type             ent_ff, ent_in;
   logic                  pos_ff, pos_in;
   logic                  tok, tok_next, above;
   logic [SIZE_W:0]       need;
   cell_stat_type         stat;

   assign tok      = pos_ff & ~pos_right;
   assign tok_next = pos_left & ~pos_ff;
   assign above    = ~pos_ff;
   assign need     = {1'b0, ctl.size} + (SIZE_W+1)'(HEADER_BYTES);

   always_comb begin
      stat.used      = ent_ff.used;
      stat.fit       = ent_ff.used & ent_ff.free & ({1'b0, ent_ff.len} >= ctl.size);
      stat.match     = ent_ff.used & (ent_ff.start == ctl.offset);
      stat.mergeable = ent_ff.used & ent_ff.free & right_ent.used & right_ent.free;
      stat.splitable = {2'b00, ent_ff.len} > need;
      stat.start     = ent_ff.start;
      stat_out       = tok ? stat : '0;
   end

   always_comb begin
      ent_in = ent_ff;
      case (ctl.op)
         OP_TAKE: begin
            if (tok) ent_in.free = 1'b0;
         end
         OP_FREE: begin
            if (tok) ent_in.free = 1'b1;
         end
         OP_SPLIT: begin
            if (tok) begin
               ent_in.len  = ctl.size[OFFSET_W-1:0];
               ent_in.free = 1'b0;
            end else if (tok_next) begin
               ent_in.used  = 1'b1;
               ent_in.free  = 1'b1;
               ent_in.start = left_ent.start + need[OFFSET_W-1:0];
               ent_in.len   = left_ent.len - need[OFFSET_W-1:0];
            end else if (above) begin
               ent_in = left_ent;
            end
         end
         OP_MERGE: begin
            if (tok) begin
               ent_in.len = ent_ff.len + OFFSET_W'(HEADER_BYTES) + right_ent.len;
            end else if (above) begin
               ent_in = right_ent;
            end
         end
         default: ent_in = ent_ff;
      endcase
   end

   always_comb begin
      pos_in = pos_ff;
      if (ctl.restart) pos_in = FIRST;
      else if (ctl.advance) pos_in = pos_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.used  <= FIRST;
         ent_ff.free  <= FIRST;
         ent_ff.start <= OFFSET_W'(HEADER_BYTES);
         ent_ff.len   <= OFFSET_W'(HEAP_BYTES - HEADER_BYTES);
         pos_ff       <= FIRST;
      end else begin
         ent_ff <= ent_in;
         pos_ff <= pos_in;
      end
   end

   assign ent_out = ent_ff;
   assign pos_out = pos_ff;

endmodule
`default_nettype wire

### hw/rtl/ffba_ctrl.sv
// Module: sequencer that walks the cell row for fit, coalesce and free.
`default_nettype none
module ffba_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   ffba_req_if.sink                 req,
   ffba_rsp_if.source               rsp,
   input  ffba_pkg::cell_stat_type  stat,
   input  wire                      last_tok,
   input  wire                      full,
   output ffba_pkg::cell_ctl_type   ctl
);
   import ffba_pkg::*;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   status_type          status_ff, status_in;
   logic [OFFSET_W-1:0] result_ff, result_in;
   logic                scan_end;
   logic                coal_end;

   assign scan_end = ~stat.used | last_tok;
   assign coal_end = ~stat.used | (~stat.mergeable & last_tok);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) state_in = (req.command == CMD_FREE) ? ST_FIND : ST_FIT1;
         end
         ST_FIT1: begin
            if (stat.fit) state_in = ST_RESP;
            else if (scan_end) state_in = ST_COAL;
         end
         ST_FIT2: begin
            if (stat.fit || scan_end) state_in = ST_RESP;
         end
         ST_COAL: begin
            if (coal_end) state_in = (cmd_ff == CMD_FREE) ? ST_RESP : ST_FIT2;
         end
         ST_FIND: begin
            if (stat.match) state_in = ST_COAL;
            else if (scan_end) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_in      = cmd_ff;
      size_in     = size_ff;
      offset_in   = offset_ff;
      status_in   = status_ff;
      result_in   = result_ff;
      ctl.op      = OP_NONE;
      ctl.restart = 1'b0;
      ctl.advance = 1'b0;
      ctl.size    = size_ff;
      ctl.offset  = offset_ff;
      req.ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req.ready   = 1'b1;
            ctl.restart = 1'b1;
            cmd_in      = req.command;
            size_in     = req.request_size;
            offset_in   = req.release_offset;
            status_in   = STS_OK;
            result_in   = '0;
         end
         ST_FIT1, ST_FIT2: begin
            if (stat.fit) begin
               ctl.op    = (stat.splitable && !full) ? OP_SPLIT : OP_TAKE;
               status_in = STS_OK;
               result_in = stat.start;
            end else if (scan_end) begin
               ctl.restart = 1'b1;
               status_in   = STS_NO_SPACE;
               result_in   = '0;
            end else begin
               ctl.advance = 1'b1;
            end
         end
         ST_COAL: begin
            if (coal_end) begin
               ctl.restart = 1'b1;
               status_in   = STS_OK;
            end else if (stat.mergeable) begin
               ctl.op = OP_MERGE;
            end else begin
               ctl.advance = 1'b1;
            end
         end
         ST_FIND: begin
            if (stat.match) begin
               ctl.op      = OP_FREE;
               ctl.restart = 1'b1;
            end else if (scan_end) begin
               status_in = STS_NOT_FOUND;
               result_in = '0;
            end else begin
               ctl.advance = 1'b1;
            end
         end
         default: ctl.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff    <= cmd_in;
      size_ff   <= size_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   assign rsp.valid          = (state_ff == ST_RESP);
   assign rsp.status         = status_ff;
   assign rsp.payload_offset = result_ff;

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && status_ff != STS_OK) |-> result_ff == '0)
      else $error("failed item carries a nonzero offset");
   a_free_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && cmd_ff == CMD_FREE) |-> status_ff != STS_NO_SPACE)
      else $error("free item answered with no-space");
   a_split_room: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SPLIT |-> !full)
      else $error("split issued on a full table");
   a_resp_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp.ready) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after response");
`endif

endmodule
`default_nettype wire
